// File: rtl/smooth_vertex_normals_assert.svh
// Assertion macros used by the checker file of the smooth vertex normals block.
`ifndef SMOOTH_VERTEX_NORMALS_ASSERT_SVH
`define SMOOTH_VERTEX_NORMALS_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SVN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("svn assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is active.
`define SVN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("svn assertion failed (next cycle)");

`endif

// File: rtl/svn_pkg.sv
// Shared constants, codes and types of the smooth vertex normals block.
package svn_pkg;
	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int POS_W = 24;
	localparam int ACC_W = 32;
	localparam int NRM_W = 16;
	localparam int EDGE_W = POS_W + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int VEC_W = 52;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(1024);
	localparam logic [CNT_W-1:0] VCOUNT_MAX = CNT_W'(MAX_VERTICES);
	localparam int NRM_ONE = 16384;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_TRI = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_TRI,
		OP_READ,
		OP_ERR
	} op_t;

	typedef struct packed {
		op_t op;
		logic [IDX_W-1:0] vertex_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [IDX_W-1:0] corner_a;
		logic [IDX_W-1:0] corner_b;
		logic [IDX_W-1:0] corner_c;
	} entry_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;
endpackage

// File: rtl/svn_ifs.sv
// Valid/ready channel interfaces for items into and results out of the block.
interface svn_req_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [svn_pkg::IDX_W-1:0] vertex_index;
	logic signed [svn_pkg::POS_W-1:0] pos_x;
	logic signed [svn_pkg::POS_W-1:0] pos_y;
	logic signed [svn_pkg::POS_W-1:0] pos_z;
	logic [svn_pkg::IDX_W-1:0] corner_a;
	logic [svn_pkg::IDX_W-1:0] corner_b;
	logic [svn_pkg::IDX_W-1:0] corner_c;

	modport source (output valid, command, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, command, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface svn_rsp_if;
	logic valid;
	logic ready;
	logic status;
	logic [svn_pkg::IDX_W-1:0] out_index;
	logic signed [svn_pkg::NRM_W-1:0] normal_x;
	logic signed [svn_pkg::NRM_W-1:0] normal_y;
	logic signed [svn_pkg::NRM_W-1:0] normal_z;

	modport source (output valid, status, out_index, normal_x, normal_y, normal_z,
		input ready);
	modport sink (input valid, status, out_index, normal_x, normal_y, normal_z,
		output ready);
endinterface

// File: rtl/svn_front.sv
// Front end: vertex count register, range checks and classification of incoming items.
module svn_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [svn_pkg::CNT_W-1:0]   cfg_data,
	svn_req_if.sink                     req,
	input  svn_pkg::back_status_t       bstat,
	input  logic                        q_full,
	output logic                        push,
	output svn_pkg::entry_t             entry
);
	logic [svn_pkg::CNT_W-1:0] vertex_count_q;
	logic [svn_pkg::CNT_W-1:0] eff_cnt;
	logic ok_vi, ok_a, ok_b, ok_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= svn_pkg::VCOUNT_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_data;
		end
	end

	assign eff_cnt = (vertex_count_q > svn_pkg::VCOUNT_MAX) ? svn_pkg::VCOUNT_MAX
		: vertex_count_q;
	assign ok_vi = {1'b0, req.vertex_index} < eff_cnt;
	assign ok_a = {1'b0, req.corner_a} < eff_cnt;
	assign ok_b = {1'b0, req.corner_b} < eff_cnt;
	assign ok_c = {1'b0, req.corner_c} < eff_cnt;

	always_comb begin
		entry.vertex_index = req.vertex_index;
		entry.pos_x = req.pos_x;
		entry.pos_y = req.pos_y;
		entry.pos_z = req.pos_z;
		entry.corner_a = req.corner_a;
		entry.corner_b = req.corner_b;
		entry.corner_c = req.corner_c;
		unique case (req.command)
			svn_pkg::CMD_LOAD: entry.op = ok_vi ? svn_pkg::OP_LOAD : svn_pkg::OP_ERR;
			svn_pkg::CMD_TRI: entry.op = (ok_a && ok_b && ok_c) ? svn_pkg::OP_TRI
				: svn_pkg::OP_ERR;
			svn_pkg::CMD_READ: entry.op = ok_vi ? svn_pkg::OP_READ : svn_pkg::OP_ERR;
			default: entry.op = svn_pkg::OP_ERR;
		endcase
	end

	// No item is taken while the accumulators are being cleared after reset.
	assign req.ready = !q_full && !bstat.clearing;
	assign push = req.valid && req.ready;
endmodule

// File: rtl/svn_queue.sv
// Short queue of classified items between the front end and the execution back end.
module svn_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  svn_pkg::entry_t   wdata,
	output logic              full,
	input  logic              pop,
	output svn_pkg::entry_t   rdata,
	output logic              empty
);
	svn_pkg::entry_t mem_q [svn_pkg::QUEUE_DEPTH];
	logic [svn_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [svn_pkg::QCNT_W-1:0] count_q;

	function automatic logic [svn_pkg::QPTR_W-1:0] ptr_next(
		input logic [svn_pkg::QPTR_W-1:0] p);
		ptr_next = (p == svn_pkg::QPTR_W'(svn_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full = (count_q == svn_pkg::QCNT_W'(svn_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
endmodule

// File: rtl/svn_norm.sv
// Iterative normalizer: shift down, sum of squares, square root and per-lane divide.
module svn_norm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [svn_pkg::VEC_W-1:0]   vx,
	input  logic signed [svn_pkg::VEC_W-1:0]   vy,
	input  logic signed [svn_pkg::VEC_W-1:0]   vz,
	output logic                               done,
	output logic signed [svn_pkg::NRM_W-1:0]   nx,
	output logic signed [svn_pkg::NRM_W-1:0]   ny,
	output logic signed [svn_pkg::NRM_W-1:0]   nz
);
	localparam int U_W = 30;
	localparam int SQ_W = 2 * U_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int LEN_W = 32;
	localparam int QB = 15;
	localparam int FRAC_SH = 15;
	localparam int DIV_W = U_W + FRAC_SH + 2;
	localparam logic [1:0] SQ_LAST = 2'd2;
	localparam logic [3:0] DIV_LAST = 4'(QB - 1);

	localparam logic [2:0] N_IDLE = 3'd0;
	localparam logic [2:0] N_MAX = 3'd1;
	localparam logic [2:0] N_SHIFT = 3'd2;
	localparam logic [2:0] N_SQ = 3'd3;
	localparam logic [2:0] N_SQEND = 3'd4;
	localparam logic [2:0] N_SQRT = 3'd5;
	localparam logic [2:0] N_DIVINIT = 3'd6;
	localparam logic [2:0] N_DIV = 3'd7;

	logic [2:0] state_q;
	logic done_q;
	logic fin_q;
	logic sq_vld_s1;
	logic [1:0] k_q;
	logic [3:0] cnt_q;

	logic signed [svn_pkg::VEC_W-1:0] vin [3];
	logic [svn_pkg::VEC_W-1:0] u_q [3];
	logic neg_q [3];
	logic [svn_pkg::VEC_W-1:0] m_q;
	logic [svn_pkg::VEC_W-1:0] m_nxt;
	logic [SQ_W-1:0] sq_s1;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] res_q;
	logic [SUM_W-1:0] bit_q;
	logic [SUM_W-1:0] trial;
	logic [LEN_W-1:0] len;
	logic [DIV_W-1:0] rem_q [3];
	logic [DIV_W-1:0] dsh_q;
	logic [QB-1:0] q_q [3];
	logic [svn_pkg::NRM_W-1:0] n_q [3];
	logic [svn_pkg::NRM_W-1:0] qe [3];

	assign vin[0] = vx;
	assign vin[1] = vy;
	assign vin[2] = vz;

	always_comb begin
		m_nxt = u_q[0];
		if (u_q[1] > m_nxt) m_nxt = u_q[1];
		if (u_q[2] > m_nxt) m_nxt = u_q[2];
	end

	assign trial = res_q + bit_q;
	assign len = (res_q[LEN_W-1:0] == '0) ? LEN_W'(1) : res_q[LEN_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qe[i] = {1'b0, q_q[i]};
		end
	end

	// Control: state, counters and the done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q <= 1'b0;
			fin_q <= 1'b0;
			sq_vld_s1 <= 1'b0;
			k_q <= '0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			sq_vld_s1 <= 1'b0;
			unique case (state_q)
				N_IDLE: if (start) state_q <= N_MAX;
				N_MAX: begin
					if (m_nxt == '0) begin
						done_q <= 1'b1;
						state_q <= N_IDLE;
					end else begin
						state_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (m_q[svn_pkg::VEC_W-1:U_W] == '0) begin
						k_q <= '0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					sq_vld_s1 <= 1'b1;
					k_q <= k_q + 1'b1;
					if (k_q == SQ_LAST) state_q <= N_SQEND;
				end
				N_SQEND: state_q <= N_SQRT;
				N_SQRT: if (bit_q[0]) state_q <= N_DIVINIT;
				N_DIVINIT: begin
					cnt_q <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						fin_q <= 1'b1;
						state_q <= N_IDLE;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (sq_vld_s1) sum_q <= sum_q + SUM_W'(sq_s1);
		unique case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vin[i][svn_pkg::VEC_W-1];
						u_q[i] <= vin[i][svn_pkg::VEC_W-1] ? svn_pkg::VEC_W'(-vin[i])
							: svn_pkg::VEC_W'(vin[i]);
					end
				end
			end
			N_MAX: begin
				m_q <= m_nxt;
				if (m_nxt == '0) begin
					for (int i = 0; i < 3; i++) n_q[i] <= '0;
				end
			end
			N_SHIFT: begin
				if (m_q[svn_pkg::VEC_W-1:U_W] != '0) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++) u_q[i] <= u_q[i] >> 1;
				end else begin
					sum_q <= '0;
				end
			end
			N_SQ: sq_s1 <= u_q[k_q][U_W-1:0] * u_q[k_q][U_W-1:0];
			N_SQEND: begin
				res_q <= '0;
				bit_q <= SUM_W'(1) << (SUM_W - 2);
			end
			N_SQRT: begin
				// One result bit per cycle of the digit-by-digit square root.
				if (sum_q >= trial) begin
					sum_q <= sum_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DIVINIT: begin
				dsh_q <= DIV_W'({len, 1'b0}) << (QB - 1);
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= (DIV_W'(u_q[i][U_W-1:0]) << FRAC_SH) + DIV_W'(len);
					q_q[i] <= '0;
				end
			end
			N_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if (rem_q[i] >= dsh_q) begin
						rem_q[i] <= rem_q[i] - dsh_q;
						q_q[i] <= {q_q[i][QB-2:0], 1'b1};
					end else begin
						q_q[i] <= {q_q[i][QB-2:0], 1'b0};
					end
				end
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
		if (fin_q) begin
			for (int i = 0; i < 3; i++) begin
				n_q[i] <= neg_q[i] ? (~qe[i] + 1'b1) : qe[i];
			end
		end
	end

	assign done = done_q;
	assign nx = n_q[0];
	assign ny = n_q[1];
	assign nz = n_q[2];
endmodule

// File: rtl/svn_back.sv
// Back end: position and accumulator memories, cross product, accumulate and result register.
module svn_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  svn_pkg::entry_t         q_head,
	output logic                    pop,
	output svn_pkg::back_status_t   bstat,
	svn_rsp_if.source               rsp
);
	localparam int IW = svn_pkg::IDX_W;
	localparam int PW = svn_pkg::POS_W;
	localparam int AW = svn_pkg::ACC_W;
	localparam int NW = svn_pkg::NRM_W;
	localparam int EW = svn_pkg::EDGE_W;
	localparam int VW = svn_pkg::VEC_W;
	localparam logic [IW-1:0] CLR_LAST = IW'(svn_pkg::MAX_VERTICES - 1);
	localparam logic [2:0] MUL_LAST = 3'd5;
	localparam logic [1:0] CORNER_LAST = 2'd2;

	localparam logic [3:0] B_CLEAR = 4'd0;
	localparam logic [3:0] B_IDLE = 4'd1;
	localparam logic [3:0] B_PA = 4'd2;
	localparam logic [3:0] B_PB = 4'd3;
	localparam logic [3:0] B_PC = 4'd4;
	localparam logic [3:0] B_EDGE = 4'd5;
	localparam logic [3:0] B_MUL = 4'd6;
	localparam logic [3:0] B_MULEND = 4'd7;
	localparam logic [3:0] B_NSTART = 4'd8;
	localparam logic [3:0] B_RDISS = 4'd9;
	localparam logic [3:0] B_RDWAIT = 4'd10;
	localparam logic [3:0] B_NWAIT = 4'd11;
	localparam logic [3:0] B_ACCRD = 4'd12;
	localparam logic [3:0] B_ACCWR = 4'd13;
	localparam logic [3:0] B_EMIT = 4'd14;

	logic signed [PW-1:0] pos_x_mem [svn_pkg::MAX_VERTICES];
	logic signed [PW-1:0] pos_y_mem [svn_pkg::MAX_VERTICES];
	logic signed [PW-1:0] pos_z_mem [svn_pkg::MAX_VERTICES];
	logic signed [AW-1:0] acc_x_mem [svn_pkg::MAX_VERTICES];
	logic signed [AW-1:0] acc_y_mem [svn_pkg::MAX_VERTICES];
	logic signed [AW-1:0] acc_z_mem [svn_pkg::MAX_VERTICES];

	logic [3:0] state_q;
	logic [IW-1:0] clr_q;
	logic [2:0] mk_q;
	logic [1:0] j_q;
	logic mul_vld_s1;
	logic rsp_valid_q;

	svn_pkg::entry_t cur_q;
	logic signed [PW-1:0] pos_rx_q, pos_ry_q, pos_rz_q;
	logic signed [AW-1:0] acc_rx_q, acc_ry_q, acc_rz_q;
	logic signed [PW-1:0] pax_q, pay_q, paz_q, pbx_q, pby_q, pbz_q;
	logic signed [EW-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic signed [EW-1:0] ma, mb;
	logic signed [svn_pkg::PROD_W-1:0] prod_s1;
	logic [2:0] mk_s1;
	logic signed [svn_pkg::PROD_W-1:0] hold_q;
	logic signed [VW-1:0] cr_q [3];
	logic signed [NW-1:0] fx_q, fy_q, fz_q;
	logic rsp_status_q;
	logic [IW-1:0] rsp_index_q;
	logic signed [NW-1:0] rsp_nx_q, rsp_ny_q, rsp_nz_q;

	logic pos_we;
	logic [IW-1:0] pos_rd_addr;
	logic [IW-1:0] corner_sel;
	logic [IW-1:0] acc_rd_addr;
	logic acc_we;
	logic [IW-1:0] acc_wr_addr;
	logic signed [AW-1:0] acc_wx, acc_wy, acc_wz;
	logic emit_go;
	logic norm_start;
	logic signed [VW-1:0] nvx, nvy, nvz;
	logic norm_done;
	logic signed [NW-1:0] nnx, nny, nnz;

	function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
		input logic signed [NW-1:0] b);
		logic signed [AW:0] s;
		s = (AW+1)'(a) + (AW+1)'(b);
		if (s[AW] != s[AW-1]) begin
			sat_add = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			sat_add = s[AW-1:0];
		end
	endfunction

	assign pop = (state_q == B_IDLE) && !q_empty;
	assign pos_we = pop && (q_head.op == svn_pkg::OP_LOAD);
	assign emit_go = (state_q == B_EMIT) && (!rsp_valid_q || rsp.ready);
	assign bstat.clearing = (state_q == B_CLEAR);

	always_comb begin
		unique case (state_q)
			B_PA: pos_rd_addr = cur_q.corner_a;
			B_PB: pos_rd_addr = cur_q.corner_b;
			default: pos_rd_addr = cur_q.corner_c;
		endcase
		unique case (j_q)
			2'd0: corner_sel = cur_q.corner_a;
			2'd1: corner_sel = cur_q.corner_b;
			default: corner_sel = cur_q.corner_c;
		endcase
	end

	assign acc_rd_addr = (state_q == B_RDISS) ? cur_q.vertex_index : corner_sel;

	always_comb begin
		acc_we = 1'b0;
		acc_wr_addr = corner_sel;
		acc_wx = '0;
		acc_wy = '0;
		acc_wz = '0;
		unique case (state_q)
			B_CLEAR: begin
				acc_we = 1'b1;
				acc_wr_addr = clr_q;
			end
			B_RDWAIT: begin
				// A read clears the entry it returns.
				acc_we = 1'b1;
				acc_wr_addr = cur_q.vertex_index;
			end
			B_ACCWR: begin
				acc_we = 1'b1;
				acc_wx = sat_add(acc_rx_q, fx_q);
				acc_wy = sat_add(acc_ry_q, fy_q);
				acc_wz = sat_add(acc_rz_q, fz_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (mk_q)
			3'd0: begin ma = e1y_q; mb = e2z_q; end
			3'd1: begin ma = e1z_q; mb = e2y_q; end
			3'd2: begin ma = e1z_q; mb = e2x_q; end
			3'd3: begin ma = e1x_q; mb = e2z_q; end
			3'd4: begin ma = e1x_q; mb = e2y_q; end
			default: begin ma = e1y_q; mb = e2x_q; end
		endcase
	end

	assign norm_start = (state_q == B_RDWAIT) || (state_q == B_NSTART);
	assign nvx = (state_q == B_RDWAIT) ? VW'(acc_rx_q) : cr_q[0];
	assign nvy = (state_q == B_RDWAIT) ? VW'(acc_ry_q) : cr_q[1];
	assign nvz = (state_q == B_RDWAIT) ? VW'(acc_rz_q) : cr_q[2];

	svn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vx     (nvx),
		.vy     (nvy),
		.vz     (nvz),
		.done   (norm_done),
		.nx     (nnx),
		.ny     (nny),
		.nz     (nnz)
	);

	// Memories with registered read data.
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_x_mem[q_head.vertex_index] <= q_head.pos_x;
			pos_y_mem[q_head.vertex_index] <= q_head.pos_y;
			pos_z_mem[q_head.vertex_index] <= q_head.pos_z;
		end
		pos_rx_q <= pos_x_mem[pos_rd_addr];
		pos_ry_q <= pos_y_mem[pos_rd_addr];
		pos_rz_q <= pos_z_mem[pos_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_x_mem[acc_wr_addr] <= acc_wx;
			acc_y_mem[acc_wr_addr] <= acc_wy;
			acc_z_mem[acc_wr_addr] <= acc_wz;
		end
		acc_rx_q <= acc_x_mem[acc_rd_addr];
		acc_ry_q <= acc_y_mem[acc_rd_addr];
		acc_rz_q <= acc_z_mem[acc_rd_addr];
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			mk_q <= '0;
			j_q <= '0;
			mul_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			mul_vld_s1 <= 1'b0;
			if (emit_go) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (pop) begin
						unique case (q_head.op)
							svn_pkg::OP_TRI: state_q <= B_PA;
							svn_pkg::OP_READ: state_q <= B_RDISS;
							svn_pkg::OP_LOAD: state_q <= B_EMIT;
							svn_pkg::OP_ERR: state_q <= B_EMIT;
						endcase
					end
				end
				B_PA: state_q <= B_PB;
				B_PB: state_q <= B_PC;
				B_PC: state_q <= B_EDGE;
				B_EDGE: begin
					mk_q <= '0;
					state_q <= B_MUL;
				end
				B_MUL: begin
					mul_vld_s1 <= 1'b1;
					mk_q <= mk_q + 1'b1;
					if (mk_q == MUL_LAST) state_q <= B_MULEND;
				end
				B_MULEND: state_q <= B_NSTART;
				B_NSTART: state_q <= B_NWAIT;
				B_RDISS: state_q <= B_RDWAIT;
				B_RDWAIT: state_q <= B_NWAIT;
				B_NWAIT: begin
					if (norm_done) begin
						j_q <= '0;
						state_q <= (cur_q.op == svn_pkg::OP_TRI) ? B_ACCRD : B_EMIT;
					end
				end
				B_ACCRD: state_q <= B_ACCWR;
				B_ACCWR: begin
					if (j_q == CORNER_LAST) begin
						state_q <= B_EMIT;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= B_ACCRD;
					end
				end
				B_EMIT: if (emit_go) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_head;
		if (state_q == B_PB) begin
			pax_q <= pos_rx_q;
			pay_q <= pos_ry_q;
			paz_q <= pos_rz_q;
		end
		if (state_q == B_PC) begin
			pbx_q <= pos_rx_q;
			pby_q <= pos_ry_q;
			pbz_q <= pos_rz_q;
		end
		if (state_q == B_EDGE) begin
			e1x_q <= EW'(pbx_q) - EW'(pax_q);
			e1y_q <= EW'(pby_q) - EW'(pay_q);
			e1z_q <= EW'(pbz_q) - EW'(paz_q);
			e2x_q <= EW'(pos_rx_q) - EW'(pax_q);
			e2y_q <= EW'(pos_ry_q) - EW'(pay_q);
			e2z_q <= EW'(pos_rz_q) - EW'(paz_q);
		end
		if (state_q == B_MUL) begin
			prod_s1 <= ma * mb;
			mk_s1 <= mk_q;
		end
		// Even products are held, odd ones complete one cross product component.
		if (mul_vld_s1) begin
			if (!mk_s1[0]) hold_q <= prod_s1;
			else cr_q[mk_s1[2:1]] <= VW'(hold_q) - VW'(prod_s1);
		end
		if ((state_q == B_NWAIT) && norm_done) begin
			fx_q <= nnx;
			fy_q <= nny;
			fz_q <= nnz;
		end
		if (emit_go) begin
			rsp_status_q <= (cur_q.op == svn_pkg::OP_ERR) ? svn_pkg::STATUS_ERR
				: svn_pkg::STATUS_OK;
			rsp_index_q <= cur_q.vertex_index;
			rsp_nx_q <= (cur_q.op == svn_pkg::OP_READ) ? fx_q : '0;
			rsp_ny_q <= (cur_q.op == svn_pkg::OP_READ) ? fy_q : '0;
			rsp_nz_q <= (cur_q.op == svn_pkg::OP_READ) ? fz_q : '0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.out_index = rsp_index_q;
	assign rsp.normal_x = rsp_nx_q;
	assign rsp.normal_y = rsp_ny_q;
	assign rsp.normal_z = rsp_nz_q;
endmodule

// File: rtl/smooth_vertex_normals.sv
// Load and rejected items go straight to the result register; reads and triangles pass the
// normalizer, which ends early for a zero accumulator or a degenerate triangle. The iterative
// normalizer shifts the vector down, takes a square root and then divides each lane. One item
// is executed at a time, so the back end takes no new item before the last one is done; a
// two-entry queue lets the input side accept while the back end works or waits.
// After reset a clearing pass zeroes the 1024 accumulators; no item is taken.
module smooth_vertex_normals (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [svn_pkg::CNT_W-1:0]   cfg_data,
	svn_req_if.sink                     req,
	svn_rsp_if.source                   rsp
);
	svn_pkg::back_status_t bstat;
	svn_pkg::entry_t push_entry;
	svn_pkg::entry_t head_entry;
	logic push, pop, q_full, q_empty;

	svn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req),
		.bstat    (bstat),
		.q_full   (q_full),
		.push     (push),
		.entry    (push_entry)
	);

	svn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.full   (q_full),
		.pop    (pop),
		.rdata  (head_entry),
		.empty  (q_empty)
	);

	svn_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (head_entry),
		.pop     (pop),
		.bstat   (bstat),
		.rsp     (rsp)
	);
endmodule

// File: rtl/svn_checker.sv
// Port-level checker of the smooth vertex normals block and its bind.
`include "smooth_vertex_normals_assert.svh"

module svn_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic                              rsp_status,
	input logic signed [svn_pkg::NRM_W-1:0]  rsp_nx,
	input logic signed [svn_pkg::NRM_W-1:0]  rsp_ny,
	input logic signed [svn_pkg::NRM_W-1:0]  rsp_nz
);
	`SVN_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`SVN_ASSERT_IMP(a_err_zero, clk, arst_n, rsp_valid && (rsp_status == svn_pkg::STATUS_ERR), (rsp_nx == 0) && (rsp_ny == 0) && (rsp_nz == 0))
	`SVN_ASSERT_IMP(a_unit_range, clk, arst_n, rsp_valid, ($signed(rsp_nx) >= -svn_pkg::NRM_ONE) && ($signed(rsp_nx) <= svn_pkg::NRM_ONE) && ($signed(rsp_ny) >= -svn_pkg::NRM_ONE) && ($signed(rsp_ny) <= svn_pkg::NRM_ONE) && ($signed(rsp_nz) >= -svn_pkg::NRM_ONE) && ($signed(rsp_nz) <= svn_pkg::NRM_ONE))
endmodule

bind smooth_vertex_normals svn_checker u_svn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_nx     (rsp.normal_x),
	.rsp_ny     (rsp.normal_y),
	.rsp_nz     (rsp.normal_z)
);
